>>> rtl/mmms_pkg.sv
// Package for the sample summary block: controller state and command/status structs.
// No dependencies.
`timescale 1ns / 1ps
package mmms_pkg;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_MEAN,
        ST_RD0,
        ST_SQ,
        ST_VAR,
        ST_SQRT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic mean_start;
        logic pass_start;
        logic pass_step;
        logic var_start;
        logic sqrt_start;
        logic emit;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic mean_done;
        logic pass_done;
        logic var_done;
        logic sqrt_done;
    } t_status;

endpackage

>>> rtl/mmms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module mmms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/mmms_ctrl.sv
// Controller state machine for the sample summary block.
// Depends on mmms_pkg.
`timescale 1ns / 1ps
module mmms_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    input  logic             i_out_ready,
    input  mmms_pkg::t_status i_status,
    output mmms_pkg::t_cmd   o_cmd,
    output logic             o_in_ready,
    output logic             o_out_valid
);
    mmms_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= mmms_pkg::ST_LOAD;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mmms_pkg::ST_LOAD: if (i_in_valid && i_in_last) n_state = mmms_pkg::ST_MEAN;
            mmms_pkg::ST_MEAN: if (i_status.mean_done) n_state = mmms_pkg::ST_RD0;
            mmms_pkg::ST_RD0:  n_state = mmms_pkg::ST_SQ;
            mmms_pkg::ST_SQ:   if (i_status.pass_done) n_state = mmms_pkg::ST_VAR;
            mmms_pkg::ST_VAR:  if (i_status.var_done) n_state = mmms_pkg::ST_SQRT;
            mmms_pkg::ST_SQRT: if (i_status.sqrt_done) n_state = mmms_pkg::ST_OUT;
            mmms_pkg::ST_OUT:  if (i_out_ready) n_state = mmms_pkg::ST_LOAD;
            default:           n_state = mmms_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            mmms_pkg::ST_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                o_cmd.mean_start = i_in_valid && i_in_last;
            end
            mmms_pkg::ST_MEAN: o_cmd.pass_start = i_status.mean_done;
            mmms_pkg::ST_RD0:  o_cmd.pass_step = 1'b1;
            mmms_pkg::ST_SQ: begin
                o_cmd.pass_step = 1'b1;
                o_cmd.var_start = i_status.pass_done;
            end
            mmms_pkg::ST_VAR:  o_cmd.sqrt_start = i_status.var_done;
            mmms_pkg::ST_SQRT: ;
            mmms_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                o_cmd.emit = 1'b1;
                o_cmd.clear = i_out_ready;
            end
            default: ;
        endcase
    end
endmodule

>>> rtl/mmms_dp.sv
// Datapath: sample store, running statistics, mean divider, squared-deviation
// pass, variance divider and square root. Depends on mmms_pkg and mmms_ram.
`timescale 1ns / 1ps
module mmms_dp #(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mmms_pkg::t_cmd    i_cmd,
    input  logic [31:0]       i_sample,
    output mmms_pkg::t_status o_status,
    output logic [31:0]       o_minimum,
    output logic [31:0]       o_maximum,
    output logic [31:0]       o_mean,
    output logic [31:0]       o_std,
    output logic [10:0]       o_total,
    output logic              o_overflowed
);
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int SW = 32 + CW;           // sum width
    localparam int QW = 66 + CW;           // squared-deviation sum width

    logic signed [31:0] w_s;
    assign w_s = 32'(signed'(i_sample[SAMPLE_BITS-1:0]));

    logic [CW-1:0]       r_cnt;
    logic signed [31:0]  r_min, r_max;
    logic signed [SW-1:0] r_sum;
    logic                r_drop;
    logic                w_keep;
    assign w_keep = i_cmd.load && (r_cnt != CW'(MAX_SAMPLES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_cnt <= '0; r_min <= '0; r_max <= '0; r_sum <= '0; r_drop <= 1'b0;
        end else if (i_cmd.load) begin
            if (w_keep) begin
                r_cnt <= r_cnt + 1'b1;
                r_sum <= r_sum + SW'(w_s);
                if (r_cnt == '0 || w_s < r_min) r_min <= w_s;
                if (r_cnt == '0 || w_s > r_max) r_max <= w_s;
            end else begin
                r_drop <= 1'b1;
            end
        end
    end

    // Start the mean division in the cycle after the last word so the count is final.
    logic r_mstart;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mstart <= 1'b0;
        else r_mstart <= i_cmd.mean_start;
    end

    // Squared-deviation accumulator, filled by the second pass below.
    logic [QW-1:0] r_acc;

    // Shared restoring divider: one quotient bit per cycle, unsigned.
    logic            r_dbusy, r_dsel_var;
    logic [6:0]      r_dcnt;
    logic [QW-1:0]   r_dnum;
    logic [QW-1:0]   r_drem;
    logic            r_dneg;
    logic [QW:0]     w_rsh;
    assign w_rsh = {r_drem, r_dnum[QW-1]};
    logic            w_ge;
    assign w_ge = w_rsh >= (QW+1)'(r_cnt);
    logic            w_ddone;
    assign w_ddone = r_dbusy && r_dcnt == 7'd0;

    logic [SW-1:0] w_abs_sum;
    assign w_abs_sum = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);

    logic signed [31:0] r_mean;
    logic [63:0]        r_var;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
        end else if (r_mstart) begin
            r_dbusy <= 1'b1; r_dsel_var <= 1'b0; r_dcnt <= 7'(SW - 1);
            r_dnum <= QW'(w_abs_sum) << (QW - SW); r_drem <= '0; r_dneg <= r_sum[SW-1];
        end else if (i_cmd.var_start) begin
            r_dbusy <= 1'b1; r_dsel_var <= 1'b1; r_dcnt <= 7'(QW - 1);
            r_dnum <= r_acc; r_drem <= '0; r_dneg <= 1'b0;
        end else if (r_dbusy) begin
            r_dnum <= {r_dnum[QW-2:0], w_ge};
            r_drem <= w_ge ? QW'(w_rsh - (QW+1)'(r_cnt)) : w_rsh[QW-1:0];
            r_dcnt <= r_dcnt - 1'b1;
            if (r_dcnt == 7'd0) r_dbusy <= 1'b0;
        end
    end

    logic [QW-1:0] w_q;
    assign w_q = {r_dnum[QW-2:0], w_ge};
    logic r_mdone, r_vdone;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mdone <= 1'b0; r_vdone <= 1'b0;
        end else begin
            r_mdone <= w_ddone && !r_dsel_var;
            r_vdone <= w_ddone && r_dsel_var;
        end
        if (w_ddone && !r_dsel_var)
            r_mean <= r_dneg ? 32'(-w_q[SW-1:0]) : 32'(w_q[SW-1:0]);
        if (w_ddone && r_dsel_var) r_var <= w_q[63:0];
    end

    // Second pass: read store, subtract mean, square, accumulate.
    logic [AW-1:0] r_raddr;
    logic [31:0]   w_rdata;
    logic [CW-1:0] r_rcnt;     // words issued
    logic          r_rvalid, r_sqv, r_sq_v2;
    logic [32:0]   r_absd;
    logic [65:0]   r_sq;
    logic          r_pdone;

    mmms_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_keep),
        .i_waddr(r_cnt[AW-1:0]),
        .i_wdata(w_s),
        .i_raddr(r_raddr),
        .o_rdata(w_rdata)
    );

    logic signed [32:0] w_d;
    assign w_d = 33'(signed'(w_rdata)) - 33'(r_mean);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.pass_start) begin
            r_raddr <= '0; r_rcnt <= '0; r_rvalid <= 1'b0; r_sqv <= 1'b0;
            r_sq_v2 <= 1'b0; r_acc <= '0; r_pdone <= 1'b0;
        end else if (i_cmd.pass_step && !r_pdone) begin
            r_rvalid <= r_rcnt != r_cnt;
            if (r_rcnt != r_cnt) begin
                r_rcnt <= r_rcnt + 1'b1;
                r_raddr <= r_raddr + 1'b1;
            end
            r_absd <= w_d[32] ? 33'(-w_d) : 33'(w_d);
            r_sqv <= r_rvalid;
            r_sq <= 66'(r_absd) * 66'(r_absd);
            r_sq_v2 <= r_sqv;
            if (r_sq_v2) r_acc <= r_acc + QW'(r_sq);
            if (!r_rvalid && !r_sqv && !r_sq_v2 && r_rcnt == r_cnt) r_pdone <= 1'b1;
        end
    end

    // Square root (digit-by-digit).
    logic [63:0] r_sv, r_res, r_bit;
    logic        r_sbusy, r_sdone;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sbusy <= 1'b0; r_sdone <= 1'b0;
        end else if (i_cmd.sqrt_start) begin
            r_sbusy <= 1'b1; r_sdone <= 1'b0;
            r_sv <= r_var; r_res <= '0; r_bit <= 64'h4000_0000_0000_0000;
        end else if (r_sbusy) begin
            if (r_bit == '0) begin
                r_sbusy <= 1'b0; r_sdone <= 1'b1;
            end else begin
                if (r_sv >= r_res + r_bit) begin
                    r_sv  <= r_sv - (r_res + r_bit);
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
        end else begin
            r_sdone <= 1'b0;
        end
    end

    // Status fields in package order: mean, pass, variance, square root.
    assign o_status = {r_mdone, r_pdone, r_vdone, r_sdone};

    assign o_minimum    = r_min;
    assign o_maximum    = r_max;
    assign o_mean       = r_mean;
    assign o_std        = r_res[31:0];
    assign o_total      = 11'(r_cnt);
    assign o_overflowed = r_drop;
    logic w_unused;
    assign w_unused = i_cmd.emit;
endmodule

>>> rtl/min_max_mean_stddev_summary.sv
// Top level of the sample summary block: controller plus datapath.
// Depends on mmms_pkg, mmms_ctrl, mmms_dp, mmms_ram.
//
//  channel | dir | tdata                    | tuser | tlast
//  s_axis  | in  | sample[31:0]             | -     | last
//  m_axis  | out | min,max,mean,std,total   | ovf   | -
//
// Samples load one word per cycle while s_axis_tready is high. After the last word
// the mean divider runs, then the squared-deviation pass (one RAM read per cycle),
// then the variance divider and last the square root.
// Reset is synchronous, active low; it clears counts and flags, not the store.
// The result is held on m_axis until taken; no sample is accepted meanwhile.
`timescale 1ns / 1ps
module min_max_mean_stddev_summary #(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // sample[31:0]
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // minimum[31:0], maximum[63:32], mean_value[95:64], std_deviation[127:96],
    // sample_total[138:128], zero fill [143:139]
    output logic [143:0] m_axis_tdata,
    output logic         m_axis_tuser    // overflowed
);
    mmms_pkg::t_cmd    w_cmd;
    mmms_pkg::t_status w_status;
    logic [31:0] w_min, w_max, w_mean, w_std;
    logic [10:0] w_total;
    logic        w_ovf;

    mmms_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_last(s_axis_tlast),
        .i_out_ready(m_axis_tready), .i_status(w_status),
        .o_cmd(w_cmd), .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid)
    );

    mmms_dp #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_sample(s_axis_tdata),
        .o_status(w_status), .o_minimum(w_min), .o_maximum(w_max), .o_mean(w_mean),
        .o_std(w_std), .o_total(w_total), .o_overflowed(w_ovf)
    );

    assign m_axis_tdata = {5'd0, w_total, w_std, w_mean, w_max, w_min};
    assign m_axis_tuser = w_ovf;

    // No sample is taken while a result waits.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input ready during result");
    // A held result stays stable until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    // The last word always leads to a pending result, never straight back to load.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("ready after last word");
endmodule

>>> dv/min_max_mean_stddev_summary_checker.sv
// Checker for the sample summary block: watches both stream channels, predicts
// each set summary and compares it field by field. Depends on nothing outside.
`timescale 1ns / 1ps
module min_max_mean_stddev_summary_checker #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,
    input  logic         s_axis_tlast,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [143:0] m_axis_tdata,
    input  logic         m_axis_tuser,
    output int           o_fail_count,
    output int           o_pending
);

    typedef struct packed {
        logic [31:0] minimum;
        logic [31:0] maximum;
        logic [31:0] mean_value;
        logic [31:0] std_deviation;
        logic [10:0] sample_total;
        logic        overflowed;
    } t_summary;

    logic signed [31:0] set_samples [MAX_SAMPLES];
    int                 set_count;
    logic signed [31:0] set_min, set_max;
    logic signed [63:0] set_sum;
    logic               set_dropped;
    t_summary           summary_queue [$];

    function automatic logic [31:0] floor_sqrt(logic [63:0] v);
        logic [63:0] root, bit_q;
        root  = 0;
        bit_q = 64'd1 << 62;
        while (bit_q > v) bit_q >>= 2;
        while (bit_q != 0) begin
            if (v >= root + bit_q) begin
                v    = v - (root + bit_q);
                root = (root >> 1) + bit_q;
            end else begin
                root >>= 1;
            end
            bit_q >>= 2;
        end
        return root[31:0];
    endfunction

    // Take one sample word; close the set and queue its summary on the last one.
    task automatic take_sample(logic signed [31:0] s, logic is_last);
        logic signed [63:0]  mean, dev;
        logic        [127:0] sq_acc;
        logic        [63:0]  mag;
        t_summary            r;
        if (set_count < MAX_SAMPLES) begin
            set_samples[set_count] = s;
            if (set_count == 0) begin
                set_min = s;
                set_max = s;
            end else begin
                if (s < set_min) set_min = s;
                if (s > set_max) set_max = s;
            end
            set_sum += s;
            set_count++;
        end else begin
            set_dropped = 1'b1;
        end
        if (is_last) begin
            mean   = set_sum / 64'(set_count);
            sq_acc = 0;
            for (int i = 0; i < set_count; i++) begin
                dev    = 64'(set_samples[i]) - mean;
                mag    = dev < 0 ? -dev : dev;
                sq_acc += 128'(mag) * 128'(mag);
            end
            r.minimum       = set_min;
            r.maximum       = set_max;
            r.mean_value    = mean[31:0];
            r.std_deviation = floor_sqrt(64'(sq_acc / 128'(set_count)));
            r.sample_total  = 11'(set_count);
            r.overflowed    = set_dropped;
            summary_queue = {summary_queue, r};
            set_count   = 0;
            set_sum     = 0;
            set_dropped = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_summary got, want;
        if (!i_rst_n) begin
            set_count    = 0;
            set_sum      = 0;
            set_dropped  = 1'b0;
            o_fail_count <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                       m_axis_tdata[127:96], m_axis_tdata[138:128], m_axis_tuser};
                if (summary_queue.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected summary word %h", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = summary_queue.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10) begin
                            $display("summary mismatch: exp min %h max %h mean %h std %h n %0d ovf %b",
                                want.minimum, want.maximum, want.mean_value,
                                want.std_deviation, want.sample_total, want.overflowed);
                            $display("                  got min %h max %h mean %h std %h n %0d ovf %b",
                                got.minimum, got.maximum, got.mean_value,
                                got.std_deviation, got.sample_total, got.overflowed);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            // Model the input after the output so a same-edge result is not popped.
            if (s_axis_tvalid && s_axis_tready)
                take_sample(s_axis_tdata, s_axis_tlast);
        end
        o_pending <= summary_queue.size();
    end

endmodule

>>> dv/min_max_mean_stddev_summary_tb.sv
// Testbench top for the sample summary block: drives sample sets with random
// gaps and back pressure, and reports the verdict. Depends on the checker and the DUT top.
`timescale 1ns / 1ps
module min_max_mean_stddev_summary_tb;

    localparam int MAX_SAMPLES = 1024;
    localparam int STALL_LIMIT = 20000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;   // sample[31:0]
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [143:0] m_axis_tdata;   // min, max, mean, std, total, zero fill
    logic         m_axis_tuser;   // overflowed
    int           fail_count;
    int           pending;
    int           idle_cycles;
    bit           quiet_phase;

    min_max_mean_stddev_summary #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(32)) dut (.*);

    min_max_mean_stddev_summary_checker #(.MAX_SAMPLES(MAX_SAMPLES)) checker_i (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: count cycles with no word moving on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: stall in random bursts until the quiet phase.
    initial begin
        int burst;
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 19);
                m_axis_tready <= 1'b0;
                repeat (burst) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    // Send one word; hold it until accepted. May insert a gap first.
    task automatic send_word(logic [31:0] value, logic is_last);
        if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= is_last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Random sample with a spread that picks extremes, small, medium or full range.
    function automatic logic [31:0] pick_sample(int spread);
        case (spread)
            0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1: return 32'($signed($urandom_range(0, 2000)) - 1000);
            2: return 32'($signed($urandom_range(0, 32'h0003_FFFF)) - 32'h0002_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_set(int n, int spread);
        for (int i = 0; i < n; i++)
            send_word(pick_sample(spread), i == n - 1);
    endtask

    initial begin
        int sent, n;
        quiet_phase   = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single samples (each extreme, zero), extremes mixed, small pairs, constant set, bit pattern pair.
        send_word(32'h7FFF_FFFF, 1'b1);
        send_word(32'h8000_0000, 1'b1);
        send_word(32'h0000_0000, 1'b1);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0002, 1'b1);
        send_word(32'hFFFF_FFFD, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
        repeat (4) send_word(32'h8000_0000, 1'b0);
        send_word(32'h8000_0000, 1'b1);
        send_word(32'h5555_5555, 1'b0);
        send_word(32'hAAAA_AAAA, 1'b1);
        sent = 16;

        // Hold the sender until every summary has come back.
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        // Full store, then overflow with dropped samples (last one dropped too).
        send_set(MAX_SAMPLES + 3, 3);
        sent += MAX_SAMPLES + 3;

        // Random sets, mostly small.
        while (sent < 1300) begin
            n = $urandom_range(0, 9) == 0 ? $urandom_range(20, 80) : $urandom_range(1, 8);
            if (sent > 1200) quiet_phase = 1'b1;
            send_set(n, $urandom_range(0, 3));
            sent += n;
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/mmms_pkg.sv
rtl/mmms_ram.sv
rtl/mmms_ctrl.sv
rtl/mmms_dp.sv
rtl/min_max_mean_stddev_summary.sv
dv/min_max_mean_stddev_summary_checker.sv
dv/min_max_mean_stddev_summary_tb.sv
